FILE: src/ritoa_pkg.sv
`default_nettype none

package ritoa_pkg;

	localparam int unsigned VALUE_WIDTH    = 32;
	localparam int unsigned RADIX_W        = 6;
	localparam int unsigned CHAR_W         = 8;
	// dividend bits retired per division cycle
	localparam int unsigned BITS_PER_CYCLE = 8;

	localparam logic [RADIX_W-1:0] RADIX_MIN   = 6'd2;
	localparam logic [RADIX_W-1:0] RADIX_MAX   = 6'd36;
	localparam logic [RADIX_W-1:0] RADIX_DEC   = 6'd10;
	localparam logic [RADIX_W-1:0] RADIX_RESET = RADIX_DEC;

	localparam logic [CHAR_W-1:0] CH_ZERO    = 8'h30;
	localparam logic [CHAR_W-1:0] CH_LOWER_A = 8'h61;
	localparam logic [CHAR_W-1:0] CH_MINUS   = 8'h2D;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DIV,
		S_SIGN,
		S_READ,
		S_EMIT
	} ritoa_state_t;

	typedef struct packed {
		logic start;
		logic div_en;
		logic rd_en;
		logic load_sign;
		logic load_digit;
	} ritoa_cmd_t;

	typedef struct packed {
		logic div_last;
		logic conv_done;
		logic neg;
		logic out_free;
		logic last_digit;
	} ritoa_stat_t;

	function automatic logic [CHAR_W-1:0] digit_char(input logic [RADIX_W-1:0] d);
		logic [CHAR_W-1:0] dx;
		dx = {2'b00, d};
		if (d < RADIX_DEC) begin
			return CH_ZERO + dx;
		end else begin
			return CH_LOWER_A + dx - {2'b00, RADIX_DEC};
		end
	endfunction

	function automatic logic [RADIX_W-1:0] clamp_radix(input logic [RADIX_W-1:0] r);
		if (r < RADIX_MIN) begin
			return RADIX_MIN;
		end else if (r > RADIX_MAX) begin
			return RADIX_MAX;
		end else begin
			return r;
		end
	endfunction

endpackage

`default_nettype wire

FILE: src/ritoa_in_if.sv
`default_nettype none

interface ritoa_in_if #(
	parameter int unsigned VALUE_WIDTH = ritoa_pkg::VALUE_WIDTH
);
	logic                          valid;
	logic                          ready;
	logic signed [VALUE_WIDTH-1:0] value;

	modport source (output valid, output value, input ready);
	modport sink (input valid, input value, output ready);
endinterface

`default_nettype wire

FILE: src/ritoa_out_if.sv
`default_nettype none

interface ritoa_out_if;
	logic                          valid;
	logic                          ready;
	logic [ritoa_pkg::CHAR_W-1:0]  char_code;
	logic                          last_char;

	modport source (output valid, output char_code, output last_char, input ready);
	modport sink (input valid, input char_code, input last_char, output ready);
endinterface

`default_nettype wire

FILE: src/radix_integer_to_ascii.sv
`default_nettype none

// channel    dir  payload                         handshake
// value_ch   in   value [VALUE_WIDTH-1:0] signed  valid/ready, transfer when both high
// char_ch    out  char_code [7:0], last_char      valid/ready, transfer when both high
// cfg        in   cfg_wr_data [5:0] (radix)       cfg_wr_en, no wait
//
// one number at a time: the value is taken, then each digit is formed in the shared
// divider, a '-' is loaded for a negative value in radix 10, then each character
// takes a digit store read and then an output register load.
// char_ch stalls hold the sequencer in place; the next value is taken while the
// last character still sits in the output register.
// arst_n clears the control state and sets the radix to 10.

module radix_integer_to_ascii #(
	parameter int unsigned VALUE_WIDTH = ritoa_pkg::VALUE_WIDTH
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_wr_en,
	input  wire logic [ritoa_pkg::RADIX_W-1:0] cfg_wr_data,
	ritoa_in_if.sink                           value_ch,
	ritoa_out_if.source                        char_ch
);

	ritoa_pkg::ritoa_cmd_t  cmd;
	ritoa_pkg::ritoa_stat_t stat;
	logic                   in_ready;

	assign value_ch.ready = in_ready;

	ritoa_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (value_ch.valid),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	ritoa_dp #(
		.VALUE_WIDTH (VALUE_WIDTH)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.value       (value_ch.value),
		.cmd         (cmd),
		.stat        (stat),
		.out_ready   (char_ch.ready),
		.out_valid   (char_ch.valid),
		.out_char    (char_ch.char_code),
		.out_last    (char_ch.last_char)
	);

endmodule

`default_nettype wire

FILE: src/ritoa_dp.sv
`default_nettype none

module ritoa_dp #(
	parameter int unsigned VALUE_WIDTH = ritoa_pkg::VALUE_WIDTH
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              cfg_wr_en,
	input  wire logic [ritoa_pkg::RADIX_W-1:0]     cfg_wr_data,
	input  wire logic signed [VALUE_WIDTH-1:0]     value,
	input  wire ritoa_pkg::ritoa_cmd_t             cmd,
	output ritoa_pkg::ritoa_stat_t                 stat,
	input  wire logic                              out_ready,
	output logic                                   out_valid,
	output logic [ritoa_pkg::CHAR_W-1:0]           out_char,
	output logic                                   out_last
);

	localparam int unsigned BPC   = ritoa_pkg::BITS_PER_CYCLE;
	localparam int unsigned ITERS = (VALUE_WIDTH + BPC - 1) / BPC;
	localparam int unsigned PW    = ITERS * BPC;
	localparam int unsigned IT_W  = (ITERS > 1) ? $clog2(ITERS) : 1;
	localparam int unsigned CNT_W = $clog2(VALUE_WIDTH + 1);
	localparam int unsigned IDX_W = $clog2(VALUE_WIDTH);
	localparam int unsigned RW    = ritoa_pkg::RADIX_W;

	logic [RW-1:0]                    radix_q;
	logic [PW-1:0]                    quo_q;
	logic [PW-1:0]                    quo_nxt;
	logic [RW-1:0]                    rem_q;
	logic [RW-1:0]                    rem_nxt;
	logic [RW:0]                      part;
	logic [BPC-1:0]                   qbits;
	logic [IT_W-1:0]                  iter_q;
	logic [CNT_W-1:0]                 count_q;
	logic [CNT_W-1:0]                 cnt_inc;
	logic [CNT_W-1:0]                 k_q;
	logic [CNT_W-1:0]                 k_dec;
	logic                             neg_q;
	logic                             neg_in;
	logic [VALUE_WIDTH-1:0]           val_u;
	logic [VALUE_WIDTH-1:0]           mag;
	logic                             div_last;
	logic [RW-1:0]                    digit_mem [VALUE_WIDTH];
	logic [RW-1:0]                    rd_q;
	logic                             out_valid_q;
	logic [ritoa_pkg::CHAR_W-1:0]     char_q;
	logic                             last_q;

	assign val_u  = value;
	assign neg_in = (radix_q == ritoa_pkg::RADIX_DEC) && val_u[VALUE_WIDTH-1];
	assign mag    = neg_in ? (VALUE_WIDTH'(0) - val_u) : val_u;

	// restoring division, BPC quotient bits per cycle, MSB first
	always_comb begin
		part  = {1'b0, rem_q};
		qbits = '0;
		for (int i = 0; i < BPC; i++) begin
			part = {part[RW-1:0], quo_q[PW-1-i]};
			if (part >= {1'b0, radix_q}) begin
				part             = part - {1'b0, radix_q};
				qbits[BPC-1-i] = 1'b1;
			end
		end
		rem_nxt = part[RW-1:0];
	end

	assign quo_nxt  = (quo_q << BPC) | PW'(qbits);
	assign cnt_inc  = count_q + 1'b1;
	assign div_last = (iter_q == IT_W'(ITERS - 1));
	assign k_dec    = k_q - 1'b1;

	assign stat.div_last   = div_last;
	assign stat.conv_done  = (quo_nxt == '0) || (cnt_inc == CNT_W'(VALUE_WIDTH));
	assign stat.neg        = neg_q;
	assign stat.out_free   = !out_valid_q || out_ready;
	assign stat.last_digit = (k_q == CNT_W'(1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radix_q <= ritoa_pkg::RADIX_RESET;
		end else if (cfg_wr_en) begin
			radix_q <= ritoa_pkg::clamp_radix(cfg_wr_data);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			iter_q  <= '0;
			count_q <= '0;
			k_q     <= '0;
			neg_q   <= 1'b0;
		end else begin
			if (cmd.start) begin
				iter_q  <= '0;
				count_q <= '0;
				neg_q   <= neg_in;
			end else if (cmd.div_en) begin
				if (div_last) begin
					iter_q  <= '0;
					count_q <= cnt_inc;
					k_q     <= cnt_inc;
				end else begin
					iter_q <= iter_q + 1'b1;
				end
			end else if (cmd.load_digit) begin
				k_q <= k_dec;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			quo_q <= PW'(mag);
			rem_q <= '0;
		end else if (cmd.div_en) begin
			quo_q <= quo_nxt;
			// remainder restarts for every new digit
			rem_q <= div_last ? '0 : rem_nxt;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.div_en && div_last) begin
			digit_mem[count_q[IDX_W-1:0]] <= rem_nxt;
		end
		if (cmd.rd_en) begin
			rd_q <= digit_mem[k_dec[IDX_W-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_sign || cmd.load_digit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_sign) begin
			char_q <= ritoa_pkg::CH_MINUS;
			last_q <= 1'b0;
		end else if (cmd.load_digit) begin
			char_q <= ritoa_pkg::digit_char(rd_q);
			last_q <= (k_q == CNT_W'(1));
		end
	end

	assign out_valid = out_valid_q;
	assign out_char  = char_q;
	assign out_last  = last_q;

endmodule

`default_nettype wire

FILE: src/ritoa_ctrl.sv
`default_nettype none

module ritoa_ctrl (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire ritoa_pkg::ritoa_stat_t stat,
	output ritoa_pkg::ritoa_cmd_t   cmd
);

	ritoa_pkg::ritoa_state_t state_q;
	ritoa_pkg::ritoa_state_t state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ritoa_pkg::S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ritoa_pkg::S_IDLE: begin
				if (in_valid) begin
					state_nxt = ritoa_pkg::S_DIV;
				end
			end
			ritoa_pkg::S_DIV: begin
				if (stat.div_last && stat.conv_done) begin
					state_nxt = stat.neg ? ritoa_pkg::S_SIGN : ritoa_pkg::S_READ;
				end
			end
			ritoa_pkg::S_SIGN: begin
				if (stat.out_free) begin
					state_nxt = ritoa_pkg::S_READ;
				end
			end
			ritoa_pkg::S_READ: begin
				state_nxt = ritoa_pkg::S_EMIT;
			end
			ritoa_pkg::S_EMIT: begin
				if (stat.out_free) begin
					state_nxt = stat.last_digit ? ritoa_pkg::S_IDLE : ritoa_pkg::S_READ;
				end
			end
			default: begin
				state_nxt = ritoa_pkg::S_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ritoa_pkg::S_IDLE: begin
				in_ready  = 1'b1;
				cmd.start = in_valid;
			end
			ritoa_pkg::S_DIV: begin
				cmd.div_en = 1'b1;
			end
			ritoa_pkg::S_SIGN: begin
				cmd.load_sign = stat.out_free;
			end
			ritoa_pkg::S_READ: begin
				cmd.rd_en = 1'b1;
			end
			ritoa_pkg::S_EMIT: begin
				cmd.load_digit = stat.out_free;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

endmodule

`default_nettype wire
